FILE: rtl/pafk_pkg.sv
package pafk_pkg;

  // Arm size and rotation depth.
  localparam int MAX_LINKS       = 4;
  localparam int CORDIC_STEPS    = 16;
  localparam int LINKS_AVAILABLE = 4;
  localparam int ATAN_ENTRIES    = 24;

  localparam int LINK_LIMIT   = (MAX_LINKS < LINKS_AVAILABLE) ? MAX_LINKS : LINKS_AVAILABLE;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int STEP_W       = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
  localparam int ATAN_IW      = $clog2(ATAN_ENTRIES);
  localparam int LINK_W       = $clog2(LINK_LIMIT + 1);
  localparam int LSEL_W       = $clog2(LINKS_AVAILABLE);

  // Field and datapath widths.
  localparam int IDX_W     = 3;
  localparam int ANG_W     = 16;
  localparam int LEN_W     = 24;
  localparam int POS_W     = 32;
  localparam int CNT_W     = 3;
  localparam int CFG_W     = 32;
  localparam int REG_IDX_W = 3;
  localparam int TURN_W    = 32;
  localparam int PROD_W    = LEN_W + TURN_W;
  localparam int CORD_W    = 35;
  localparam int Z_W       = 34;
  localparam int DELTA_W   = CORD_W - 8;
  localparam int SUM_W     = POS_W + 2;

  // Inverse CORDIC gain, 0.607 in Q.32.
  localparam logic [TURN_W-1:0] INV_GAIN = 32'h9B74EDA8;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_BASE_X     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE_Y     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LINK_COUNT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH_0   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH_1   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH_2   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH_3   = 3'd6;

  typedef struct packed {
    logic load;
    logic link_mul;
    logic link_prep;
    logic rot_step;
    logic link_acc;
    logic out_write;
  } pafk_cmd_t;

  typedef struct packed {
    logic links_done;
    logic step_last;
    logic out_free;
  } pafk_sts_t;

  // Arctangent of 2^-i in 32 bit turn units.
  function automatic logic [TURN_W-1:0] atan_at(input logic [ATAN_IW-1:0] i);
    logic [TURN_W-1:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/pafk_in_if.sv
interface pafk_in_if import pafk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] joint_sel;
  logic [ANG_W-1:0] angle_0;
  logic [ANG_W-1:0] angle_1;
  logic [ANG_W-1:0] angle_2;
  logic [ANG_W-1:0] angle_3;

  modport source (output valid, joint_sel, angle_0, angle_1, angle_2, angle_3,
                  input ready);
  modport sink   (input valid, joint_sel, angle_0, angle_1, angle_2, angle_3,
                  output ready);
endinterface

FILE: rtl/pafk_out_if.sv
interface pafk_out_if import pafk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    saturated;

  modport source (output valid, pos_x, pos_y, saturated, input ready);
  modport sink   (input valid, pos_x, pos_y, saturated, output ready);
endinterface

FILE: rtl/pafk_ctrl.sv
module pafk_ctrl import pafk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pafk_sts_t sts,
  output pafk_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_PREP,
    S_ROT,
    S_ACC,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && in_valid && in_ready_r;
    cmd.link_mul  = (state_r == S_MUL);
    cmd.link_prep = (state_r == S_PREP);
    cmd.rot_step  = (state_r == S_ROT);
    cmd.link_acc  = (state_r == S_ACC);
    cmd.out_write = (state_r == S_FINISH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= S_CHECK;
            in_ready_r <= 1'b0;
          end
        end
        S_CHECK: begin
          state_r <= sts.links_done ? S_FINISH : S_MUL;
        end
        S_MUL: begin
          state_r <= S_PREP;
        end
        S_PREP: begin
          state_r <= S_ROT;
        end
        S_ROT: begin
          if (sts.step_last) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          state_r <= S_CHECK;
        end
        S_FINISH: begin
          if (sts.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: rtl/pafk_dp.sv
module pafk_dp import pafk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic [IDX_W-1:0]        in_joint_sel,
  input  logic [ANG_W-1:0]        in_angle [LINKS_AVAILABLE],
  input  pafk_cmd_t               cmd,
  output pafk_sts_t               sts,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic                    out_saturated
);

  // Configuration registers.
  logic signed [POS_W-1:0] base_x_r;
  logic signed [POS_W-1:0] base_y_r;
  logic [CNT_W-1:0]        link_count_r;
  logic [LEN_W-1:0]        len_r [LINKS_AVAILABLE];

  // Item registers.
  logic [ANG_W-1:0]        angle_r [LINKS_AVAILABLE];
  logic [LINK_W-1:0]       idx_r;
  logic [LINK_W-1:0]       k_r;
  logic [ANG_W-1:0]        theta_r;
  logic [TURN_W-1:0]       prod_r;
  logic signed [CORD_W-1:0] x_r;
  logic signed [CORD_W-1:0] y_r;
  logic signed [Z_W-1:0]   z_r;
  logic [STEP_W-1:0]       step_r;
  logic signed [POS_W-1:0] px_r;
  logic signed [POS_W-1:0] py_r;
  logic                    sat_r;

  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_pos_x_r;
  logic signed [POS_W-1:0] out_pos_y_r;
  logic                    out_sat_r;

  logic [LINK_W-1:0]        n_eff;
  logic [LINK_W-1:0]        idx_clamped;
  logic [LSEL_W-1:0]        ksel;
  logic [PROD_W-1:0]        mul_full;
  logic                     flip;
  logic signed [CORD_W-1:0] x_start;
  logic signed [Z_W-1:0]    z_start;
  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;
  logic signed [Z_W-1:0]    at;
  logic signed [CORD_W-1:0] x_rnd;
  logic signed [CORD_W-1:0] y_rnd;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic signed [POS_W-1:0]  px_nxt;
  logic signed [POS_W-1:0]  py_nxt;
  logic                     sat_x;
  logic                     sat_y;

  function automatic logic signed [POS_W-1:0] add_clamp(
    input  logic signed [POS_W-1:0]   a,
    input  logic signed [DELTA_W-1:0] b,
    output logic                      hit
  );
    logic signed [SUM_W-1:0] s;
    logic signed [POS_W-1:0] r;
    s   = SUM_W'(a) + SUM_W'(b);
    hit = 1'b0;
    r   = s[POS_W-1:0];
    if (s > SUM_W'($signed({1'b0, {(POS_W-1){1'b1}}}))) begin
      hit = 1'b1;
      r   = {1'b0, {(POS_W-1){1'b1}}};
    end else if (s < SUM_W'($signed({1'b1, {(POS_W-1){1'b0}}}))) begin
      hit = 1'b1;
      r   = {1'b1, {(POS_W-1){1'b0}}};
    end
    return r;
  endfunction

  // A link count of zero behaves as one; large counts stop at the limit.
  always_comb begin
    if (link_count_r == '0) begin
      n_eff = LINK_W'(1);
    end else if (32'(link_count_r) > LINK_LIMIT) begin
      n_eff = LINK_W'(LINK_LIMIT);
    end else begin
      n_eff = LINK_W'(link_count_r);
    end
    if (32'(in_joint_sel) > 32'(n_eff)) begin
      idx_clamped = n_eff;
    end else begin
      idx_clamped = LINK_W'(in_joint_sel);
    end
  end

  assign ksel     = k_r[LSEL_W-1:0];
  assign mul_full = PROD_W'(len_r[ksel]) * PROD_W'(INV_GAIN);

  // Left half plane: start from the negated vector and take half a turn off.
  assign flip    = ANG_W'(theta_r + ANG_W'(16'h4000)) >> (ANG_W - 1) != '0;
  assign x_start = flip ? -$signed(CORD_W'(prod_r)) : $signed(CORD_W'(prod_r));
  assign z_start = Z_W'($signed({theta_r[ANG_W-1] ^ flip, theta_r[ANG_W-2:0],
                                  {(TURN_W-ANG_W){1'b0}}}));

  assign xs = x_r >>> step_r;
  assign ys = y_r >>> step_r;
  assign at = $signed(Z_W'(atan_at(ATAN_IW'(step_r))));

  assign x_rnd = x_r + CORD_W'(128);
  assign y_rnd = y_r + CORD_W'(128);
  assign dx    = x_rnd[CORD_W-1:8];
  assign dy    = y_rnd[CORD_W-1:8];

  always_comb begin
    px_nxt = add_clamp(px_r, dx, sat_x);
    py_nxt = add_clamp(py_r, dy, sat_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r     <= '0;
      base_y_r     <= '0;
      link_count_r <= CNT_W'(4);
      for (int i = 0; i < LINKS_AVAILABLE; i++) begin
        len_r[i] <= LEN_W'(65536);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_X:     base_x_r        <= $signed(cfg_data[POS_W-1:0]);
        REG_BASE_Y:     base_y_r        <= $signed(cfg_data[POS_W-1:0]);
        REG_LINK_COUNT: link_count_r    <= cfg_data[CNT_W-1:0];
        REG_LENGTH_0:   len_r[0]        <= cfg_data[LEN_W-1:0];
        REG_LENGTH_1:   len_r[1]        <= cfg_data[LEN_W-1:0];
        REG_LENGTH_2:   len_r[2]        <= cfg_data[LEN_W-1:0];
        REG_LENGTH_3:   len_r[3]        <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle_r <= in_angle;
      idx_r   <= idx_clamped;
      k_r     <= '0;
      theta_r <= '0;
      px_r    <= base_x_r;
      py_r    <= base_y_r;
      sat_r   <= 1'b0;
    end
    if (cmd.link_mul) begin
      theta_r <= theta_r + angle_r[ksel];
      prod_r  <= mul_full[PROD_W-1:LEN_W];
    end
    if (cmd.link_prep) begin
      x_r    <= x_start;
      y_r    <= '0;
      z_r    <= z_start;
      step_r <= '0;
    end
    if (cmd.rot_step) begin
      if (!z_r[Z_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
      step_r <= step_r + STEP_W'(1);
    end
    if (cmd.link_acc) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      sat_r <= sat_r | sat_x | sat_y;
      k_r   <= k_r + LINK_W'(1);
    end
    if (cmd.out_write) begin
      out_pos_x_r <= px_r;
      out_pos_y_r <= py_r;
      out_sat_r   <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_write) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.links_done = (k_r == idx_r);
  assign sts.step_last  = (step_r == STEP_W'(CORDIC_ITERS - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_pos_x     = out_pos_x_r;
  assign out_pos_y     = out_pos_y_r;
  assign out_saturated = out_sat_r;

endmodule

FILE: rtl/planar_arm_forward_kinematics.sv
// Channel  Direction  Handshake          Payload
// in_chan  sink       valid / ready      joint_sel, angle_0 .. angle_3
// out_chan source     valid / ready      pos_x, pos_y, saturated
// cfg_*    sink       cfg_we (no ready)  cfg_index, cfg_data
//
// One transaction processes L links from acceptance to a valid result, L being the
// clamped joint index (four at most); the next input is taken only after the result is written.
// Each link costs a check, a multiply by the inverse gain, a setup, 16 steps of the shared
// CORDIC rotator and an accumulate. Reset is synchronous and active low; it restores the
// register defaults and empties the result register. A waiting result does not block input:
// the next transaction is computed and then holds in its last cycle until the slot is free.
module planar_arm_forward_kinematics import pafk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pafk_in_if.sink              in_chan,
  pafk_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  pafk_cmd_t        cmd;
  pafk_sts_t        sts;
  logic [ANG_W-1:0] angle_w [LINKS_AVAILABLE];

  // The four relative joint angles travel to the datapath as one array.
  assign angle_w[0] = in_chan.angle_0;
  assign angle_w[1] = in_chan.angle_1;
  assign angle_w[2] = in_chan.angle_2;
  assign angle_w[3] = in_chan.angle_3;

  // The controller sequences the links and the rotation steps of each link.
  pafk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the rotator, the running position and the
  // output register.
  pafk_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_joint_sel   (in_chan.joint_sel),
    .in_angle       (angle_w),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .out_pos_x      (out_chan.pos_x),
    .out_pos_y      (out_chan.pos_y),
    .out_saturated  (out_chan.saturated)
  );

endmodule

FILE: rtl/pafk_checker.sv
module pafk_checker import pafk_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [POS_W-1:0] out_pos_x,
  input logic signed [POS_W-1:0] out_pos_y,
  input logic                    out_saturated
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pos_x) && $stable(out_pos_y)
                                && $stable(out_saturated))
    else $error("result payload changed while stalled");

  // The block works on one transaction at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind planar_arm_forward_kinematics pafk_checker u_pafk_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_pos_x     (out_chan.pos_x),
  .out_pos_y     (out_chan.pos_y),
  .out_saturated (out_chan.saturated)
);
